// ----- rtl/core/bloom_filter_four_hash_macros.svh -----
// ----------------------------------------------------------------------------
// Bloom filter assertion macros
// Shorthand for clocked assertions that are disabled while reset is low.
// ----------------------------------------------------------------------------
`ifndef BLOOM_FILTER_FOUR_HASH_MACROS_SVH
`define BLOOM_FILTER_FOUR_HASH_MACROS_SVH

// same-cycle implication
`define BFF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BFF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/bff_pkg.sv -----
// ----------------------------------------------------------------------------
// Bloom filter package
// Widths, constants and state codes of the four-hash Bloom filter.
// ----------------------------------------------------------------------------
package bff_pkg;

  localparam int unsigned MaxBitsDefault = 1024;

  // size register and hash values
  localparam int unsigned SizeW = 11;
  localparam int unsigned CharW = 8;
  // remainder holds one shifted-in bit above the modulus
  localparam int unsigned RemW  = SizeW + 1;
  // widest pre-reduction value: first-char hash term
  localparam int unsigned ProdW = 20;
  // bits of the dividend retired per reduction cycle
  localparam int unsigned DigitW = 4;
  localparam int unsigned Passes = ProdW / DigitW;
  localparam int unsigned CntW   = 3;

  typedef logic [SizeW-1:0] size_t;
  typedef logic [ProdW-1:0] prod_t;

  localparam size_t SizeReset    = size_t'(100);
  localparam size_t SumReset     = size_t'(0);
  localparam size_t PolyReset    = size_t'(1);
  localparam size_t Mul31Reset   = size_t'(7);
  localparam size_t FirstReset   = size_t'(3);
  localparam size_t PowerReset   = size_t'(1);

  localparam int unsigned Pow19Base = 19;
  localparam int unsigned Mul31Base = 31;
  localparam int unsigned Pow7Base  = 7;
  localparam int unsigned FirstShift = 3;

  // reduction lanes
  localparam int unsigned NumLanes  = 6;
  localparam int unsigned LaneSum   = 0;
  localparam int unsigned LanePoly  = 1;
  localparam int unsigned LanePow19 = 2;
  localparam int unsigned LaneMul31 = 3;
  localparam int unsigned LaneFirst = 4;
  localparam int unsigned LanePow7  = 5;

  localparam logic OpInsert = 1'b0;
  localparam logic OpLookup = 1'b1;

  localparam logic [2:0] StClear  = 3'd0;
  localparam logic [2:0] StIdle   = 3'd1;
  localparam logic [2:0] StReduce = 3'd2;
  localparam logic [2:0] StRead   = 3'd3;
  localparam logic [2:0] StWrite  = 3'd4;
  localparam logic [2:0] StDone   = 3'd5;

endpackage

// ----- rtl/core/bloom_filter_four_hash.sv -----
// ----------------------------------------------------------------------------
// Four-hash Bloom filter
// Keys arrive one character per transfer; four running hashes are reduced
// modulo the configured size and tested against a one-bit-wide store.
// ----------------------------------------------------------------------------
// channel   direction  handshake               payload
// command   in         start / busy            operation_i, char_code_i, last_char_i
// result    out        done_o (strobe)         maybe_present_o, was_inserted_o, index_*_o
// config    in         cfg_valid_i/cfg_ready_o cfg_data_i (table size)
//
// A character's products are formed and registered on acceptance, then its
// remainder is reduced in StReduce (4 bits per cycle over 20-bit values, six lanes).
// A last character then passes through the store reads in StRead, the writes
// in StWrite when an insert finds the key absent, and the result in StDone.
// After reset a clearing pass zeroes every bit of the store, busy high.
// Results are shown for one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
module bloom_filter_four_hash
  import bff_pkg::*;
#(
  parameter  int unsigned MAX_BITS = MaxBitsDefault,
  localparam int unsigned IdxW     = $clog2(MAX_BITS)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic             operation_i,
  input  logic [CharW-1:0] char_code_i,
  input  logic             last_char_i,
  output logic             done_o,
  output logic             maybe_present_o,
  output logic             was_inserted_o,
  output logic [IdxW-1:0]  index_sum_o,
  output logic [IdxW-1:0]  index_pow19_o,
  output logic [IdxW-1:0]  index_mul31_o,
  output logic [IdxW-1:0]  index_first_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [SizeW-1:0] cfg_data_i
);

  function automatic logic [RemW-1:0] rem_digit(input logic [RemW-1:0]   r_in,
                                                input logic [DigitW-1:0] dig,
                                                input size_t             m);
    logic [RemW-1:0] r;
    r = r_in;
    for (int j = DigitW - 1; j >= 0; j--) begin
      r = {r[RemW-2:0], dig[j]};
      if (r >= {1'b0, m}) begin
        r = r - {1'b0, m};
      end
    end
    return r;
  endfunction

  // hash values are reduced modulo the clamped size, so they stay below MAX_BITS
  function automatic logic [IdxW-1:0] to_idx(input size_t h);
    logic [SizeW+IdxW-1:0] e;
    e = {{IdxW{1'b0}}, h};
    return e[IdxW-1:0];
  endfunction

  logic [2:0]       state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [IdxW-1:0]  clr_q;
  size_t            ts_q, m_eff, m_q;
  logic             op_q, last_q;
  logic             mid_q, present_q, ins_q;
  logic [CharW-1:0] fc_q, fc_in;
  size_t            sum_q, pol_q, m31_q, fch_q, p19_q, p7_q;

  prod_t            x_q   [NumLanes];
  prod_t            x_in  [NumLanes];
  logic [RemW-1:0]  rem_q [NumLanes];
  logic [RemW-1:0]  rem_d [NumLanes];

  logic             accept, red_last, present_fin;
  size_t            hsel;

  logic             mem_q [MAX_BITS];
  logic             rd_q;
  logic             mem_we, mem_wdata;
  logic [IdxW-1:0]  mem_addr;

  assign accept      = start && !busy;
  assign busy        = (state_q != StIdle);
  assign cfg_ready_o = 1'b1;
  assign red_last    = (cnt_q == CntW'(Passes - 1));
  assign present_fin = present_q & rd_q;

  always_comb begin
    m_eff = ts_q;
    if (ts_q == '0) begin
      m_eff = size_t'(1);
    end else if (32'(ts_q) > MAX_BITS) begin
      m_eff = size_t'(MAX_BITS);
    end
  end

  // products for one character
  always_comb begin
    fc_in               = mid_q ? fc_q : char_code_i;
    x_in[LaneSum]       = prod_t'(sum_q) + prod_t'(char_code_i);
    x_in[LanePoly]      = prod_t'(pol_q) + prod_t'(p19_q) * prod_t'(char_code_i);
    x_in[LanePow19]     = prod_t'(p19_q) * prod_t'(Pow19Base);
    x_in[LaneMul31]     = prod_t'(m31_q) * prod_t'(Mul31Base) + prod_t'(char_code_i);
    x_in[LaneFirst]     = (prod_t'(fch_q) << FirstShift) + prod_t'(fc_in) * prod_t'(p7_q);
    x_in[LanePow7]      = prod_t'(p7_q) * prod_t'(Pow7Base);
  end

  always_comb begin
    for (int k = 0; k < NumLanes; k++) begin
      rem_d[k] = rem_digit(rem_q[k], x_q[k][ProdW-1 -: DigitW], m_q);
    end
  end

  always_comb begin
    case (cnt_q[1:0])
      2'd0:    hsel = sum_q;
      2'd1:    hsel = pol_q;
      2'd2:    hsel = m31_q;
      default: hsel = fch_q;
    endcase
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    mem_we    = 1'b0;
    mem_wdata = 1'b0;
    mem_addr  = to_idx(hsel);
    unique case (state_q)
      StClear: begin
        mem_we   = 1'b1;
        mem_addr = clr_q;
        if (clr_q == IdxW'(MAX_BITS - 1)) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (accept) begin
          state_d = StReduce;
          cnt_d   = '0;
        end
      end
      StReduce: begin
        cnt_d = cnt_q + 1'b1;
        if (red_last) begin
          cnt_d   = '0;
          state_d = last_q ? StRead : StIdle;
        end
      end
      StRead: begin
        // reads issued at counts 0..3, data consumed at counts 1..4
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(4)) begin
          cnt_d   = '0;
          state_d = (op_q == OpInsert && !present_fin) ? StWrite : StDone;
        end
      end
      StWrite: begin
        mem_we    = 1'b1;
        mem_wdata = 1'b1;
        cnt_d     = cnt_q + 1'b1;
        if (cnt_q == CntW'(3)) begin
          state_d = StDone;
        end
      end
      StDone: begin
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StClear;
      cnt_q     <= '0;
      clr_q     <= '0;
      ts_q      <= SizeReset;
      mid_q     <= 1'b0;
      present_q <= 1'b1;
      ins_q     <= 1'b0;
      fc_q      <= '0;
      sum_q     <= SumReset;
      pol_q     <= PolyReset;
      m31_q     <= Mul31Reset;
      fch_q     <= FirstReset;
      p19_q     <= PowerReset;
      p7_q      <= PowerReset;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (cfg_valid_i && cfg_ready_o) begin
        ts_q <= cfg_data_i;
      end
      if (state_q == StClear) begin
        clr_q <= clr_q + 1'b1;
      end
      if (accept) begin
        mid_q <= 1'b1;
        if (!mid_q) begin
          fc_q <= char_code_i;
        end
      end
      if (state_q == StReduce && red_last) begin
        sum_q     <= rem_d[LaneSum][SizeW-1:0];
        pol_q     <= rem_d[LanePoly][SizeW-1:0];
        p19_q     <= rem_d[LanePow19][SizeW-1:0];
        m31_q     <= rem_d[LaneMul31][SizeW-1:0];
        fch_q     <= rem_d[LaneFirst][SizeW-1:0];
        p7_q      <= rem_d[LanePow7][SizeW-1:0];
        present_q <= 1'b1;
        ins_q     <= 1'b0;
      end
      if (state_q == StRead && cnt_q != '0) begin
        present_q <= present_fin;
        if (cnt_q == CntW'(4)) begin
          ins_q <= (op_q == OpInsert) && !present_fin;
        end
      end
      if (state_q == StDone) begin
        mid_q <= 1'b0;
        fc_q  <= '0;
        sum_q <= SumReset;
        pol_q <= PolyReset;
        m31_q <= Mul31Reset;
        fch_q <= FirstReset;
        p19_q <= PowerReset;
        p7_q  <= PowerReset;
      end
    end
  end

  // reduction datapath, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      m_q    <= m_eff;
      op_q   <= operation_i;
      last_q <= last_char_i;
      for (int k = 0; k < NumLanes; k++) begin
        x_q[k]   <= x_in[k];
        rem_q[k] <= '0;
      end
    end else if (state_q == StReduce) begin
      for (int k = 0; k < NumLanes; k++) begin
        x_q[k]   <= x_q[k] << DigitW;
        rem_q[k] <= rem_d[k];
      end
    end
  end

  // bit store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= mem_wdata;
    end
    rd_q <= mem_q[mem_addr];
  end

  assign done_o          = (state_q == StDone);
  assign maybe_present_o = present_q;
  assign was_inserted_o  = ins_q;
  assign index_sum_o     = to_idx(sum_q);
  assign index_pow19_o   = to_idx(pol_q);
  assign index_mul31_o   = to_idx(m31_q);
  assign index_first_o   = to_idx(fch_q);

endmodule

// ----- rtl/core/bff_checker.sv -----
// ----------------------------------------------------------------------------
// Bloom filter port checker
// Watches the command and result ports of the four-hash Bloom filter.
// ----------------------------------------------------------------------------
`include "bloom_filter_four_hash_macros.svh"

module bff_checker
  import bff_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done_o,
  input logic maybe_present_o,
  input logic was_inserted_o
);

  localparam logic StrobeOn = 1'b1;

  // a result only appears while a command is still in flight
  `BFF_ASSERT_IMP(a_done_busy, done_o == StrobeOn, busy, "result strobe while idle")
  // a transfer on the command side makes the block busy
  `BFF_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted command left block idle")
  // one key gives one result, then the block frees up
  `BFF_ASSERT_NXT(a_done_free, done_o, !done_o && !busy, "result not followed by idle")
  // bits are set only when the key was absent
  `BFF_ASSERT_IMP(a_ins_absent, done_o && was_inserted_o, !maybe_present_o,
                  "insert reported for a present key")

endmodule

bind bloom_filter_four_hash bff_checker u_bff_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .done_o         (done_o),
  .maybe_present_o(maybe_present_o),
  .was_inserted_o (was_inserted_o)
);

// ----- tb/bloom_filter_four_hash_test.sv -----
// ----------------------------------------------------------------------------
// Four-hash Bloom filter testbench
// Sends keys one character at a time, directed and random, over several table
// sizes, and compares every result against an in-bench filter and hash copy.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module bloom_filter_four_hash_test;
  import bff_pkg::*;

  localparam int unsigned IDX_W          = $clog2(MaxBitsDefault);
  localparam int unsigned SETTLE_CYCLES  = 24;
  localparam int unsigned WATCHDOG_LIMIT = 6000;
  localparam int unsigned IDLE_PCT       = 26;
  localparam int unsigned PHASE_CHARS    = 148;

  typedef struct packed {
    logic             present;
    logic             inserted;
    logic [IDX_W-1:0] idx_sum;
    logic [IDX_W-1:0] idx_pow19;
    logic [IDX_W-1:0] idx_mul31;
    logic [IDX_W-1:0] idx_first;
  } probe_result_t;

  typedef struct packed {
    logic [3:0]                len;
    logic [7:0][CharW-1:0]     chars;
  } key_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic             operation_i = OpInsert;
  logic [CharW-1:0] char_code_i = '0;
  logic             last_char_i = 1'b0;
  logic             done_o;
  logic             maybe_present_o;
  logic             was_inserted_o;
  logic [IDX_W-1:0] index_sum_o;
  logic [IDX_W-1:0] index_pow19_o;
  logic [IDX_W-1:0] index_mul31_o;
  logic [IDX_W-1:0] index_first_o;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [SizeW-1:0] cfg_data_i = '0;

  bloom_filter_four_hash DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .operation_i     (operation_i),
    .char_code_i     (char_code_i),
    .last_char_i     (last_char_i),
    .done_o          (done_o),
    .maybe_present_o (maybe_present_o),
    .was_inserted_o  (was_inserted_o),
    .index_sum_o     (index_sum_o),
    .index_pow19_o   (index_pow19_o),
    .index_mul31_o   (index_mul31_o),
    .index_first_o   (index_first_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // in-bench filter: store, running hashes and size register
  logic             filter_bits [MaxBitsDefault];
  logic [SizeW-1:0] size_reg;
  logic [IDX_W-1:0] sum_h, pow19_h, mul31_h, first_h, p19, p7;
  logic [CharW-1:0] key_first_ch;
  logic             in_key;

  probe_result_t pending_probes [$];
  probe_result_t exp_r;

  int unsigned mismatches    = 0;
  int unsigned results_seen  = 0;
  int unsigned chars_sent    = 0;
  int unsigned keys_inserted = 0;
  int unsigned keys_hit      = 0;
  int unsigned size_settings = 0;
  int unsigned quiet_cycles  = 0;
  bit          steady_sender = 1'b0;

  function automatic void restart_key();
    sum_h        = IDX_W'(SumReset);
    pow19_h      = IDX_W'(PolyReset);
    mul31_h      = IDX_W'(Mul31Reset);
    first_h      = IDX_W'(FirstReset);
    p19          = IDX_W'(PowerReset);
    p7           = IDX_W'(PowerReset);
    key_first_ch = '0;
    in_key       = 1'b0;
  endfunction

  // advance the four hashes by one character; on the last one probe the store
  function automatic void hash_and_probe(input logic op, input logic [CharW-1:0] ch,
                                         input logic last);
    int unsigned   m;
    probe_result_t r;
    m = 32'(size_reg);
    if (m == 0) m = 1;
    if (m > MaxBitsDefault) m = MaxBitsDefault;
    if (!in_key) begin
      key_first_ch = ch;
      in_key = 1'b1;
    end
    sum_h   = IDX_W'((32'(sum_h) + 32'(ch)) % m);
    pow19_h = IDX_W'((32'(pow19_h) + 32'(p19) * 32'(ch)) % m);
    p19     = IDX_W'((32'(p19) * Pow19Base) % m);
    mul31_h = IDX_W'((32'(mul31_h) * Mul31Base + 32'(ch)) % m);
    first_h = IDX_W'(((32'(first_h) << FirstShift) + 32'(key_first_ch) * 32'(p7)) % m);
    p7      = IDX_W'((32'(p7) * Pow7Base) % m);
    if (last) begin
      r.idx_sum   = sum_h;
      r.idx_pow19 = pow19_h;
      r.idx_mul31 = mul31_h;
      r.idx_first = first_h;
      r.present   = filter_bits[sum_h] && filter_bits[pow19_h] &&
                    filter_bits[mul31_h] && filter_bits[first_h];
      r.inserted  = (op == OpInsert) && !r.present;
      if (r.inserted) begin
        filter_bits[sum_h]   = 1'b1;
        filter_bits[pow19_h] = 1'b1;
        filter_bits[mul31_h] = 1'b1;
        filter_bits[first_h] = 1'b1;
        keys_inserted++;
      end
      if (r.present) keys_hit++;
      pending_probes.push_back(r);
      restart_key();
    end
  endfunction

  // one character transfer; start is left high so a following call keeps it up
  task automatic send_char(input logic op, input logic [CharW-1:0] ch, input logic last);
    operation_i <= op;
    char_code_i <= ch;
    last_char_i <= last;
    // random idle cycles, drawn every cycle until the transfer happens
    do begin
      start <= steady_sender || ($urandom_range(99) >= IDLE_PCT);
      @(posedge clk_i);
    end while (!(start && !busy));
    chars_sent++;
    hash_and_probe(op, ch, last);
  endtask

  task automatic send_key(input key_t k, input logic op);
    for (int i = 0; i < k.len; i++) begin
      if (i == k.len - 1) send_char(op, k.chars[i], 1'b1);
      else send_char(1'($urandom_range(1)), k.chars[i], 1'b0);
    end
  endtask

  // hold off until every result is in, then let a trailing character finish
  task automatic wait_drained();
    start <= 1'b0;
    while (pending_probes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_size(input logic [SizeW-1:0] sz);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= sz;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    size_reg = sz;
    size_settings++;
  endtask

  // result checker: the receiver cannot stall, so every strobe is a transfer
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      results_seen++;
      if (pending_probes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result present=%0b ins=%0b idx=%0d/%0d/%0d/%0d",
                   maybe_present_o, was_inserted_o, index_sum_o, index_pow19_o,
                   index_mul31_o, index_first_o);
      end else begin
        exp_r = pending_probes.pop_front();
        if (exp_r.present !== maybe_present_o || exp_r.inserted !== was_inserted_o ||
            exp_r.idx_sum !== index_sum_o || exp_r.idx_pow19 !== index_pow19_o ||
            exp_r.idx_mul31 !== index_mul31_o || exp_r.idx_first !== index_first_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: result %0d exp %0b/%0b %0d/%0d/%0d/%0d got %0b/%0b %0d/%0d/%0d/%0d",
                     results_seen, exp_r.present, exp_r.inserted, exp_r.idx_sum,
                     exp_r.idx_pow19, exp_r.idx_mul31, exp_r.idx_first,
                     maybe_present_o, was_inserted_o, index_sum_o, index_pow19_o,
                     index_mul31_o, index_first_o);
        end
      end
    end
  end

  // watchdog: cycles without any transfer on any channel
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("ERROR: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // default size: single- and multi-character keys, repeat insert, lookups, byte extremes
  task automatic test_single_char_keys();
    send_char(OpInsert, 8'h41, 1'b1);
    send_char(OpInsert, 8'h41, 1'b1);
    send_char(OpLookup, 8'h41, 1'b1);
    send_char(OpLookup, 8'h00, 1'b0);
    send_char(OpLookup, 8'hFF, 1'b1);
    send_char(OpInsert, 8'hFF, 1'b0);
    send_char(OpInsert, 8'hFF, 1'b0);
    send_char(OpInsert, 8'hFF, 1'b1);
  endtask

  // size above the store is clamped, zero acts as one, then a size of one is used
  task automatic test_size_extremes();
    write_size(11'h7FF);
    send_char(OpInsert, 8'hFF, 1'b0);
    send_char(OpInsert, 8'h00, 1'b0);
    send_char(OpInsert, 8'h80, 1'b1);
    send_char(OpLookup, 8'hFF, 1'b0);
    send_char(OpLookup, 8'h00, 1'b0);
    send_char(OpLookup, 8'h80, 1'b1);
    write_size('0);
    send_char(OpInsert, 8'h07, 1'b1);
    send_char(OpLookup, 8'hC8, 1'b1);
    write_size(SizeW'(1));
    send_char(OpInsert, 8'h55, 1'b1);
  endtask

  task automatic test_size_change_mid_key();
    write_size(SizeW'(MaxBitsDefault));
    send_char(OpInsert, 8'h41, 1'b0);
    send_char(OpLookup, 8'hFE, 1'b0);
    write_size(SizeW'(37));
    send_char(OpInsert, 8'h10, 1'b1);
  endtask

  // random keys over several sizes; a pool of earlier keys brings repeats
  task automatic test_random_keys();
    logic [SizeW-1:0] sizes [9];
    key_t             pool [$];
    key_t             k;
    logic             op;
    int unsigned      phase_start;
    sizes[0] = SizeW'(1);
    sizes[1] = SizeW'(MaxBitsDefault);
    sizes[2] = 11'h7FF;
    sizes[3] = '0;
    sizes[4] = SizeW'(13);
    sizes[5] = SizeW'($urandom_range(2, MaxBitsDefault - 1));
    sizes[6] = SizeReset;
    sizes[7] = SizeW'(512);
    sizes[8] = SizeW'($urandom_range(MaxBitsDefault + 1, 2047));
    for (int p = 0; p < 9; p++) begin
      write_size(sizes[p]);
      steady_sender = (p == 4);
      phase_start = chars_sent;
      while (chars_sent - phase_start < PHASE_CHARS) begin
        if (pool.size() != 0 && $urandom_range(99) < 40) begin
          k = pool[$urandom_range(pool.size() - 1)];
        end else begin
          k.len = 4'($urandom_range(1, ($urandom_range(9) == 0) ? 8 : 5));
          for (int i = 0; i < 8; i++) begin
            case ($urandom_range(9))
              0:       k.chars[i] = 8'h00;
              1:       k.chars[i] = 8'hFF;
              default: k.chars[i] = 8'($urandom_range(255));
            endcase
          end
          pool.push_back(k);
          if (pool.size() > 64) void'(pool.pop_front());
        end
        op = ($urandom_range(99) < 55) ? OpInsert : OpLookup;
        send_key(k, op);
        if ($urandom_range(199) == 0) wait_drained();
      end
      // leave a key open across the size change now and then
      if ($urandom_range(1)) begin
        repeat ($urandom_range(1, 3))
          send_char(1'($urandom_range(1)), 8'($urandom_range(255)), 1'b0);
      end
    end
    steady_sender = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < MaxBitsDefault; i++) filter_bits[i] = 1'b0;
    size_reg = SizeReset;
    restart_key();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_single_char_keys();
    test_size_extremes();
    test_size_change_mid_key();
    test_random_keys();
    wait_drained();

    if (pending_probes.size() != 0) begin
      mismatches += pending_probes.size();
      $display("ERROR: %0d results never arrived", pending_probes.size());
    end
    $display("covered %0d characters, %0d keys probed over %0d size settings",
             chars_sent, results_seen, size_settings);
    $display("%0d keys set new bits, %0d found present, %0d mismatches",
             keys_inserted, keys_hit, mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
